[sv/assert_macros.svh]
// Assertion macros shared by the bank timing block.
// Define ASSERT_OFF to compile the checks out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_PROP(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
	else $error("bank timing check failed");
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
	else $error("bank timing forbidden condition");
`else
`define ASSERT_PROP(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

[sv/dbtr_pkg.sv]
// Shared types, constants and saturating helpers for the bank timing block.
// No dependencies.
package dbtr_pkg;
	localparam int TS_W = 48;
	localparam logic [TS_W-1:0] TMAX = {TS_W{1'b1}};
	typedef logic [TS_W-1:0] ts_t;

	localparam int BANKS_PER_RANK_D    = 16;
	localparam int RANKS_D             = 2;
	localparam int BANK_GROUPS_D       = 4;
	localparam int LINES_PER_ROW_D     = 32;
	localparam int CHANNELS_D          = 2;
	localparam int ACT_HISTORY_DEPTH_D = 8;

	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] REG_CORE     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TURN     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ACTWIN   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_BURST    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_RETLAT   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_MAXACC   = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_POLICY   = 3'd6;

	localparam logic [1:0] POL_OPEN      = 2'd0;
	localparam logic [1:0] POL_CLOSE     = 2'd1;
	localparam logic [1:0] POL_OPEN_ADP  = 2'd2;
	localparam logic [1:0] POL_CLOSE_ADP = 2'd3;

	// one step command per controller state
	typedef struct packed {
		logic capture;
		logic load;
		logic pre;
		logic act;
		logic apply;
		logic col;
		logic dready;
		logic finish;
		logic close;
	} ctl_t;

	// saturating add, flag in the top bit
	function automatic logic [TS_W:0] tadd(input ts_t a, input ts_t b);
		logic [TS_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		if (s[TS_W]) s = {1'b1, TMAX};
		return s;
	endfunction

	function automatic ts_t umax(input ts_t a, input ts_t b);
		return (a > b) ? a : b;
	endfunction
endpackage

[sv/dram_bank_timing_reserve_top.sv]
// DRAM bank timing reservation, one channel.
// Start is taken only in idle; the sequencer then steps load, pre, act, apply, col,
// drdy, finish and close, with busy high from load to close and done high in close.
// Reset: bank, history, burst and config state resets at once; request registers do not.
// Results show for one cycle with done; the receiver cannot stall.
module dram_bank_timing_reserve_top import dbtr_pkg::*; #(
	parameter int BANKS_PER_RANK    = BANKS_PER_RANK_D,
	parameter int RANKS             = RANKS_D,
	parameter int BANK_GROUPS       = BANK_GROUPS_D,
	parameter int LINES_PER_ROW     = LINES_PER_ROW_D,
	parameter int CHANNELS          = CHANNELS_D,
	parameter int ACT_HISTORY_DEPTH = ACT_HISTORY_DEPTH_D
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  logic [31:0]          line_address,
	input  logic                 write_req,
	input  logic [47:0]          select_cycle,
	input  logic                 same_row_pending,
	input  logic                 other_row_pending,
	output logic                 done,
	output logic                 row_hit,
	output logic [47:0]          precharge_cycle,
	output logic [47:0]          activate_cycle,
	output logic [47:0]          command_cycle,
	output logic [47:0]          data_ready_cycle,
	output logic [47:0]          response_cycle,
	output logic                 auto_close,
	output logic [47:0]          next_event_cycle,
	output logic                 time_overflow,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [63:0]          cfg_data
);
`include "assert_macros.svh"

	ctl_t ctl;

	assign cfg_ready = 1'b1;

	dbtr_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.done   (done),
		.ctl    (ctl)
	);

	dbtr_datapath #(
		.BANKS_PER_RANK    (BANKS_PER_RANK),
		.RANKS             (RANKS),
		.BANK_GROUPS       (BANK_GROUPS),
		.LINES_PER_ROW     (LINES_PER_ROW),
		.CHANNELS          (CHANNELS),
		.ACT_HISTORY_DEPTH (ACT_HISTORY_DEPTH)
	) u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.ctl               (ctl),
		.cfg_we            (cfg_valid && cfg_ready),
		.cfg_index         (cfg_index),
		.cfg_data          (cfg_data),
		.line_address      (line_address),
		.write_req         (write_req),
		.select_cycle      (select_cycle),
		.same_row_pending  (same_row_pending),
		.other_row_pending (other_row_pending),
		.row_hit           (row_hit),
		.precharge_cycle   (precharge_cycle),
		.activate_cycle    (activate_cycle),
		.command_cycle     (command_cycle),
		.data_ready_cycle  (data_ready_cycle),
		.response_cycle    (response_cycle),
		.auto_close        (auto_close),
		.next_event_cycle  (next_event_cycle),
		.time_overflow     (time_overflow)
	);

	// sequencer checks
	`ASSERT_PROP(a_accept_busy, clk, arst_n, (start && !busy) |=> busy)
	`ASSERT_PROP(a_done_in_busy, clk, arst_n, done |-> busy)
	`ASSERT_PROP(a_done_frees, clk, arst_n, done |=> (!busy && !done))
	`ASSERT_NEVER(a_one_step, clk, arst_n, ctl.capture && ctl.close)
endmodule

[sv/dbtr_ctrl.sv]
// Step sequencer for the bank timing block.
// Depends on dbtr_pkg.
module dbtr_ctrl import dbtr_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	output logic done,
	output ctl_t ctl
);
	typedef enum logic [3:0] {
		S_IDLE, S_LOAD, S_PRE, S_ACT, S_APPLY, S_COL, S_DRDY, S_FIN, S_CLOSE
	} state_t;

	state_t state_q;

	// advance one step per cycle, waiting in idle for start
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE:  if (start) state_q <= S_LOAD;
				S_LOAD:  state_q <= S_PRE;
				S_PRE:   state_q <= S_ACT;
				S_ACT:   state_q <= S_APPLY;
				S_APPLY: state_q <= S_COL;
				S_COL:   state_q <= S_DRDY;
				S_DRDY:  state_q <= S_FIN;
				S_FIN:   state_q <= S_CLOSE;
				S_CLOSE: state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign busy = (state_q != S_IDLE);
	assign done = (state_q == S_CLOSE);

	// decode step commands
	always_comb begin
		ctl = '0;
		ctl.capture = (state_q == S_IDLE) && start;
		ctl.load    = (state_q == S_LOAD);
		ctl.pre     = (state_q == S_PRE);
		ctl.act     = (state_q == S_ACT);
		ctl.apply   = (state_q == S_APPLY);
		ctl.col     = (state_q == S_COL);
		ctl.dready  = (state_q == S_DRDY);
		ctl.finish  = (state_q == S_FIN);
		ctl.close   = (state_q == S_CLOSE);
	end
endmodule

[sv/dbtr_datapath.sv]
// Bank state, activation history, configuration and timing arithmetic.
// Depends on dbtr_pkg; steered by dbtr_ctrl.
module dbtr_datapath import dbtr_pkg::*; #(
	parameter int BANKS_PER_RANK    = BANKS_PER_RANK_D,
	parameter int RANKS             = RANKS_D,
	parameter int BANK_GROUPS       = BANK_GROUPS_D,
	parameter int LINES_PER_ROW     = LINES_PER_ROW_D,
	parameter int CHANNELS          = CHANNELS_D,
	parameter int ACT_HISTORY_DEPTH = ACT_HISTORY_DEPTH_D
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  ctl_t                 ctl,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [63:0]          cfg_data,
	input  logic [31:0]          line_address,
	input  logic                 write_req,
	input  ts_t                  select_cycle,
	input  logic                 same_row_pending,
	input  logic                 other_row_pending,
	output logic                 row_hit,
	output ts_t                  precharge_cycle,
	output ts_t                  activate_cycle,
	output ts_t                  command_cycle,
	output ts_t                  data_ready_cycle,
	output ts_t                  response_cycle,
	output logic                 auto_close,
	output ts_t                  next_event_cycle,
	output logic                 time_overflow
);
	localparam int NB    = RANKS * BANKS_PER_RANK;
	localparam int BIW   = (NB > 1) ? $clog2(NB) : 1;
	localparam int BKW   = (BANKS_PER_RANK > 1) ? $clog2(BANKS_PER_RANK) : 1;
	localparam int RKW   = (RANKS > 1) ? $clog2(RANKS) : 1;
	localparam int BGW   = (BANK_GROUPS > 1) ? $clog2(BANK_GROUPS) : 1;
	localparam int D     = ACT_HISTORY_DEPTH;
	localparam int HW    = (D > 1) ? $clog2(D) : 1;
	localparam int CW    = $clog2(D + 1);
	localparam int LDIV  = CHANNELS * LINES_PER_ROW;
	localparam int RDIV  = BANKS_PER_RANK * RANKS;
	localparam bit HAS_OTHER_RANK = (RANKS > 1);
	localparam bit HAS_OTHER_BG   = (BANK_GROUPS > 1) && (BANKS_PER_RANK > 1);

	// configuration registers
	logic [63:0] core_q, turn_q;
	logic [23:0] actwin_q;
	logic [7:0]  burst_q, maxacc_q;
	logic [15:0] retlat_q;
	logic [1:0]  policy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			core_q   <= '0;
			turn_q   <= '0;
			actwin_q <= '0;
			burst_q  <= 8'd4;
			retlat_q <= '0;
			maxacc_q <= '0;
			policy_q <= POL_OPEN;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_CORE:   core_q   <= cfg_data;
				REG_TURN:   turn_q   <= cfg_data;
				REG_ACTWIN: actwin_q <= cfg_data[23:0];
				REG_BURST:  burst_q  <= cfg_data[7:0];
				REG_RETLAT: retlat_q <= cfg_data[15:0];
				REG_MAXACC: maxacc_q <= cfg_data[7:0];
				REG_POLICY: policy_q <= cfg_data[1:0];
				default: ;
			endcase
		end
	end

	// timing fields
	logic [7:0] t_cl, t_cwl, t_rcd, t_rcdw, t_rp, t_ras, t_rtp, t_wr;
	logic [7:0] t_rrd, t_rrdl, t_ccdl, t_ccdlw, t_rtw, t_wtr, t_wtrl, t_cs;
	logic [7:0] lim_raw;
	logic [CW-1:0] lim_eff;

	always_comb begin
		t_cl    = core_q[7:0];
		t_cwl   = (core_q[15:8] == 8'd0) ? core_q[7:0] : core_q[15:8];
		t_rcd   = core_q[23:16];
		t_rcdw  = (core_q[31:24] == 8'd0) ? core_q[23:16] : core_q[31:24];
		t_rp    = core_q[39:32];
		t_ras   = core_q[47:40];
		t_rtp   = core_q[55:48];
		t_wr    = core_q[63:56];
		t_rrd   = turn_q[7:0];
		t_rrdl  = turn_q[15:8];
		t_ccdl  = turn_q[23:16];
		t_ccdlw = turn_q[31:24];
		t_rtw   = turn_q[39:32];
		t_wtr   = turn_q[47:40];
		t_wtrl  = turn_q[55:48];
		t_cs    = turn_q[63:56];
		lim_raw = actwin_q[23:16];
		lim_eff = (32'(lim_raw) > 32'(D)) ? CW'(D) : CW'(lim_raw);
	end

	// bank, rank and history state
	logic              bank_open_q  [NB];
	logic [31:0]       bank_row_q   [NB];
	ts_t               rd_ready_q   [NB];
	ts_t               wr_ready_q   [NB];
	ts_t               pre_ready_q  [NB];
	ts_t               act_ready_q  [NB];
	logic [7:0]        acc_q        [NB];
	ts_t               hist_q       [RANKS][D];
	logic [HW-1:0]     head_q       [RANKS];
	logic [CW-1:0]     cnt_q        [RANKS];
	ts_t               nbf_q;

	// request registers
	logic          wr_req_q, srp_q, orp_q;
	ts_t           ev_q;
	logic [31:0]   row_q;
	logic [BIW-1:0] bi_q;
	logic [RKW-1:0] rank_q;
	logic [BGW-1:0] bg_q;

	// step registers
	logic open_q, hit_q, hfull_q, hsum_ovf_q, ovf_q, autop_q;
	logic [31:0] orow_q;
	ts_t prr_q, arr_q, rdr_q, wrr_q, hsum_q, pre_q, arr2_q, act_q;
	ts_t prr2_q, rdr2_q, wrr2_q, cmd_q, ready_q, resp_q, prr3_q, nev_q;

	// decode the line into bank, rank and row
	logic [31:0] above, above2;
	logic [BKW-1:0] dec_bank;
	logic [RKW-1:0] dec_rank;
	logic [BIW-1:0] dec_bi;
	always_comb begin
		above    = line_address / LDIV;
		above2   = above / BANKS_PER_RANK;
		dec_bank = BKW'(above % BANKS_PER_RANK);
		dec_rank = RKW'(above2 % RANKS);
		dec_bi   = BIW'(32'(dec_rank) * BANKS_PER_RANK + 32'(dec_bank));
	end

	// combinational step values
	logic [TS_W:0] s_hsum, s_prp, s_ras, s_rcd, s_rcdw, s_spl, s_sp;
	logic [TS_W:0] s_rdy, s_nb, s_go, s_rs, s_rd, s_ws, s_wd, s_resp, s_pr, s_cls;
	ts_t pre_v, act_v;
	logic conflict;
	logic [8:0] lat_bl, g_o, off_v;
	logic [9:0] rg_s, rg_d, wg_s, wg_d;
	logic [7:0] acc_new;
	logic cap_v, adp_v;
	// history push for the request's rank
	logic [CW-1:0] h_c, h_c1, h_cf;
	logic [HW-1:0] h_h, h_h1, h_h2, h_widx;
	logic [CW:0]   h_t;

	always_comb begin
		s_hsum   = tadd(hist_q[rank_q][head_q[rank_q]], TS_W'(actwin_q[15:0]));
		pre_v    = umax(ev_q, prr_q);
		s_prp    = tadd(pre_v, TS_W'(t_rp));
		conflict = open_q && (orow_q != row_q);
		act_v    = umax(ev_q, arr2_q);
		if (hfull_q) act_v = umax(act_v, hsum_q);
		s_ras  = tadd(act_q, TS_W'(t_ras));
		s_rcd  = tadd(act_q, TS_W'(t_rcd));
		s_rcdw = tadd(act_q, TS_W'(t_rcdw));
		s_spl  = tadd(act_q, TS_W'((t_rrdl > t_rrd) ? t_rrdl : t_rrd));
		s_sp   = tadd(act_q, TS_W'(t_rrd));

		h_c = cnt_q[rank_q];
		h_h = head_q[rank_q];
		if (32'(h_c) < D) begin
			h_t    = (CW+1)'(h_h) + (CW+1)'(h_c);
			h_widx = (32'(h_t) >= D) ? HW'(32'(h_t) - D) : HW'(h_t);
			h_c1   = h_c + 1'b1;
			h_h1   = h_h;
		end else begin
			h_widx = h_h;
			h_c1   = h_c;
			h_t    = (CW+1)'(h_h) + 1'b1;
			h_h1   = (32'(h_t) >= D) ? HW'(32'(h_t) - D) : HW'(h_t);
		end
		h_cf = (h_c1 > lim_eff) ? lim_eff : h_c1;
		h_t  = (CW+1)'(h_h1) + (CW+1)'(h_c1 - h_cf);
		h_h2 = (32'(h_t) >= D) ? HW'(32'(h_t) - D) : HW'(h_t);

		lat_bl = (wr_req_q ? {1'b0, t_cwl} : {1'b0, t_cl}) + {1'b0, burst_q};
		s_rdy  = tadd(cmd_q, TS_W'(lat_bl));
		s_nb   = tadd(cmd_q, TS_W'(burst_q));
		g_o    = {1'b0, burst_q} + {1'b0, t_cs};
		if (wr_req_q) begin
			rg_d = {2'b0, t_cwl} + {2'b0, burst_q} + {2'b0, t_wtr};
			rg_s = {2'b0, t_cwl} + {2'b0, burst_q} + {2'b0, t_wtrl};
			if (rg_s < {2'b0, t_ccdl}) rg_s = {2'b0, t_ccdl};
			wg_d = {2'b0, burst_q};
			wg_s = (t_ccdlw > burst_q) ? {2'b0, t_ccdlw} : {2'b0, burst_q};
		end else begin
			rg_d = {2'b0, burst_q};
			rg_s = (t_ccdl > burst_q) ? {2'b0, t_ccdl} : {2'b0, burst_q};
			wg_d = {2'b0, burst_q} + {2'b0, t_rtw};
			wg_s = (wg_d < {2'b0, t_ccdl}) ? {2'b0, t_ccdl} : wg_d;
		end
		s_go = tadd(cmd_q, TS_W'(g_o));
		s_rs = tadd(cmd_q, TS_W'(rg_s));
		s_rd = tadd(cmd_q, TS_W'(rg_d));
		s_ws = tadd(cmd_q, TS_W'(wg_s));
		s_wd = tadd(cmd_q, TS_W'(wg_d));

		s_resp  = tadd(ready_q, TS_W'(retlat_q));
		s_pr    = wr_req_q ? tadd(ready_q, TS_W'(t_wr)) : tadd(cmd_q, TS_W'(t_rtp));
		acc_new = (acc_q[bi_q] != 8'hFF) ? acc_q[bi_q] + 8'd1 : acc_q[bi_q];
		cap_v   = (maxacc_q != 8'd0) && (acc_new >= maxacc_q);
		adp_v   = (policy_q == POL_CLOSE) ||
		          ((policy_q == POL_CLOSE_ADP) && !srp_q) ||
		          ((policy_q == POL_OPEN_ADP) && orp_q && !srp_q);
		off_v   = {1'b0, t_rp} + {1'b0, ((t_rcd > t_rcdw) ? t_rcd : t_rcdw)};

		s_cls = tadd(prr3_q, TS_W'(t_rp));
	end

	// step registers, overflow accumulation
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovf_q   <= 1'b0;
			autop_q <= 1'b0;
			hit_q   <= 1'b0;
		end else begin
			if (ctl.capture) begin
				wr_req_q <= write_req;
				srp_q    <= same_row_pending;
				orp_q    <= other_row_pending;
				ev_q     <= select_cycle;
				row_q    <= above / RDIV;
				bi_q     <= dec_bi;
				rank_q   <= dec_rank;
				bg_q     <= BGW'(32'(dec_bank) % BANK_GROUPS);
				ovf_q    <= 1'b0;
			end
			if (ctl.load) begin
				open_q     <= bank_open_q[bi_q];
				orow_q     <= bank_row_q[bi_q];
				prr_q      <= pre_ready_q[bi_q];
				arr_q      <= act_ready_q[bi_q];
				rdr_q      <= rd_ready_q[bi_q];
				wrr_q      <= wr_ready_q[bi_q];
				hsum_q     <= s_hsum[TS_W-1:0];
				hsum_ovf_q <= s_hsum[TS_W];
				hfull_q    <= (lim_eff != '0) && (cnt_q[rank_q] >= lim_eff);
			end
			if (ctl.pre) begin
				hit_q  <= open_q && (orow_q == row_q);
				pre_q  <= conflict ? pre_v : '0;
				arr2_q <= conflict ? umax(arr_q, s_prp[TS_W-1:0]) : arr_q;
				if (conflict && s_prp[TS_W]) ovf_q <= 1'b1;
			end
			if (ctl.act) begin
				act_q <= hit_q ? '0 : act_v;
				if (!hit_q && hfull_q && hsum_ovf_q) ovf_q <= 1'b1;
			end
			if (ctl.apply) begin
				prr2_q <= hit_q ? prr_q : umax(prr_q, s_ras[TS_W-1:0]);
				rdr2_q <= hit_q ? rdr_q : umax(rdr_q, s_rcd[TS_W-1:0]);
				wrr2_q <= hit_q ? wrr_q : umax(wrr_q, s_rcdw[TS_W-1:0]);
				if (!hit_q && (s_ras[TS_W] || s_rcd[TS_W] || s_rcdw[TS_W] || s_spl[TS_W]))
					ovf_q <= 1'b1;
			end
			if (ctl.col) begin
				cmd_q <= umax(umax(ev_q, wr_req_q ? wrr2_q : rdr2_q), nbf_q);
			end
			if (ctl.dready) begin
				ready_q <= s_rdy[TS_W-1:0];
				if (s_rdy[TS_W] || s_nb[TS_W] || s_rs[TS_W] || s_ws[TS_W] ||
				    (HAS_OTHER_RANK && s_go[TS_W]) ||
				    (HAS_OTHER_BG && (s_rd[TS_W] || s_wd[TS_W])))
					ovf_q <= 1'b1;
			end
			if (ctl.finish) begin
				resp_q  <= wr_req_q ? ready_q : s_resp[TS_W-1:0];
				prr3_q  <= umax(prr2_q, s_pr[TS_W-1:0]);
				autop_q <= cap_v || adp_v;
				nev_q   <= umax(ev_q, (nbf_q > TS_W'(off_v)) ? nbf_q - TS_W'(off_v) : '0);
				if ((!wr_req_q && s_resp[TS_W]) || s_pr[TS_W]) ovf_q <= 1'b1;
			end
		end
	end

	// per-bank and per-rank state, all banks updated in parallel
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int p = 0; p < NB; p++) begin
				bank_open_q[p] <= 1'b0;
				bank_row_q[p]  <= '0;
				rd_ready_q[p]  <= '0;
				wr_ready_q[p]  <= '0;
				pre_ready_q[p] <= '0;
				act_ready_q[p] <= '0;
				acc_q[p]       <= '0;
			end
			for (int r = 0; r < RANKS; r++) begin
				for (int j = 0; j < D; j++) hist_q[r][j] <= '0;
				head_q[r] <= '0;
				cnt_q[r]  <= '0;
			end
			nbf_q <= '0;
		end else begin
			// open the row and space out activations in the rank
			if (ctl.apply && !hit_q) begin
				bank_open_q[bi_q] <= 1'b1;
				bank_row_q[bi_q]  <= row_q;
				acc_q[bi_q]       <= '0;
				pre_ready_q[bi_q] <= umax(prr_q, s_ras[TS_W-1:0]);
				rd_ready_q[bi_q]  <= umax(rdr_q, s_rcd[TS_W-1:0]);
				wr_ready_q[bi_q]  <= umax(wrr_q, s_rcdw[TS_W-1:0]);
				for (int p = 0; p < NB; p++) begin
					if (RKW'(p / BANKS_PER_RANK) == rank_q) begin
						if (BIW'(p) == bi_q)
							act_ready_q[p] <= umax(arr2_q, s_spl[TS_W-1:0]);
						else if (BGW'((p % BANKS_PER_RANK) % BANK_GROUPS) == bg_q)
							act_ready_q[p] <= umax(act_ready_q[p], s_spl[TS_W-1:0]);
						else
							act_ready_q[p] <= umax(act_ready_q[p], s_sp[TS_W-1:0]);
					end
				end
				if (lim_eff != '0) begin
					hist_q[rank_q][h_widx] <= act_q;
					cnt_q[rank_q]  <= h_cf;
					head_q[rank_q] <= h_h2;
				end
			end
			// column gaps for every bank
			if (ctl.dready) begin
				nbf_q <= s_nb[TS_W-1:0];
				for (int p = 0; p < NB; p++) begin
					if (RKW'(p / BANKS_PER_RANK) != rank_q) begin
						rd_ready_q[p] <= umax(rd_ready_q[p], s_go[TS_W-1:0]);
						wr_ready_q[p] <= umax(wr_ready_q[p], s_go[TS_W-1:0]);
					end else if (BGW'((p % BANKS_PER_RANK) % BANK_GROUPS) == bg_q) begin
						rd_ready_q[p] <= umax(rd_ready_q[p], s_rs[TS_W-1:0]);
						wr_ready_q[p] <= umax(wr_ready_q[p], s_ws[TS_W-1:0]);
					end else begin
						rd_ready_q[p] <= umax(rd_ready_q[p], s_rd[TS_W-1:0]);
						wr_ready_q[p] <= umax(wr_ready_q[p], s_wd[TS_W-1:0]);
					end
				end
			end
			if (ctl.finish) begin
				pre_ready_q[bi_q] <= umax(prr2_q, s_pr[TS_W-1:0]);
				acc_q[bi_q]       <= acc_new;
			end
			// auto precharge closes the row
			if (ctl.close && autop_q) begin
				bank_open_q[bi_q] <= 1'b0;
				act_ready_q[bi_q] <= umax(act_ready_q[bi_q], s_cls[TS_W-1:0]);
			end
		end
	end

	assign row_hit          = hit_q;
	assign precharge_cycle  = autop_q ? prr3_q : pre_q;
	assign activate_cycle   = act_q;
	assign command_cycle    = cmd_q;
	assign data_ready_cycle = ready_q;
	assign response_cycle   = resp_q;
	assign auto_close       = autop_q;
	assign next_event_cycle = nev_q;
	assign time_overflow    = ovf_q || (autop_q && s_cls[TS_W]);
endmodule
